// File: design/dpq_pkg.sv
// Package for the DNS reverse (PTR) query builder.
// Holds the transaction types, packet layout constants and the decimal and tail helpers.
// No dependencies.
`default_nettype none

package dpq_pkg;

    // Request transaction.
    typedef struct packed {
        logic        is_ipv4;
        logic [31:0] address;
        logic [15:0] transaction_id;
    } dpq_req_t;

    // Result transaction: one packet byte.
    typedef struct packed {
        logic [7:0] packet_byte;
        logic       is_last;
        logic       rejected;
        logic [5:0] packet_length;
    } dpq_rsp_t;

    // One octet written in decimal, most significant present digit first.
    typedef struct packed {
        logic [1:0]      ndig;
        logic [2:0][3:0] digit;
    } dpq_dec_t;

    // Descriptor of one query, worked out when the request is taken.
    typedef struct packed {
        logic                 rejected;
        logic [15:0]          transaction_id;
        logic [3:0][1:0]      ndig;
        logic [3:0][2:0][3:0] digit;
        logic [3:0][4:0]      start;
        logic [4:0]           tail_start;
        logic [5:0]           packet_length;
    } dpq_prep_t;

    localparam int HDR_LEN  = 12;
    localparam int TAIL_LEN = 18;

    localparam logic [3:0] HDR_ID_HI  = 4'd0;
    localparam logic [3:0] HDR_ID_LO  = 4'd1;
    localparam logic [3:0] HDR_QDC_LO = 4'd5;

    localparam logic [15:0] QTYPE_PTR = 16'h000C;
    localparam logic [15:0] QCLASS_IN = 16'h0001;
    localparam logic [7:0]  ASCII_ZERO = 8'h30;

    // Splits an octet into decimal digits without leading zeros.
    function automatic dpq_dec_t to_dec(input logic [7:0] v);
        dpq_dec_t    d;
        logic [7:0]  hund;
        logic [7:0]  r8;
        logic [6:0]  r;
        logic [14:0] prod;
        logic [3:0]  h;
        logic [3:0]  t;
        logic [6:0]  t10;
        logic [6:0]  u7;
        logic [3:0]  u;
        h    = (v >= 8'd200) ? 4'd2 : ((v >= 8'd100) ? 4'd1 : 4'd0);
        hund = (v >= 8'd200) ? 8'd200 : ((v >= 8'd100) ? 8'd100 : 8'd0);
        r8   = v - hund;
        r    = r8[6:0];
        // Divide by ten through a reciprocal, exact for values below one hundred.
        prod = {8'd0, r} * 15'd205;
        t    = prod[14:11];
        t10  = {3'd0, t} * 7'd10;
        u7   = r - t10;
        u    = u7[3:0];
        if (h != 4'd0) begin
            d.ndig  = 2'd3;
            d.digit = {u, t, h};
        end else if (t != 4'd0) begin
            d.ndig  = 2'd2;
            d.digit = {4'd0, u, t};
        end else begin
            d.ndig  = 2'd1;
            d.digit = {4'd0, 4'd0, u};
        end
        return d;
    endfunction

    // Fixed tail of the question: in-addr and arpa labels, root, QTYPE and QCLASS.
    function automatic logic [7:0] tail_byte(input logic [4:0] t);
        logic [7:0] b;
        case (t)
            5'd0:    b = 8'd7;
            5'd1:    b = 8'h69;   // i
            5'd2:    b = 8'h6E;   // n
            5'd3:    b = 8'h2D;   // -
            5'd4:    b = 8'h61;   // a
            5'd5:    b = 8'h64;   // d
            5'd6:    b = 8'h64;   // d
            5'd7:    b = 8'h72;   // r
            5'd8:    b = 8'd4;
            5'd9:    b = 8'h61;   // a
            5'd10:   b = 8'h72;   // r
            5'd11:   b = 8'h70;   // p
            5'd12:   b = 8'h61;   // a
            5'd13:   b = 8'd0;
            5'd14:   b = QTYPE_PTR[15:8];
            5'd15:   b = QTYPE_PTR[7:0];
            5'd16:   b = QCLASS_IN[15:8];
            5'd17:   b = QCLASS_IN[7:0];
            default: b = 8'd0;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// File: design/dpq_prep.sv
// Request decoder: turns an accepted request into a query descriptor.
// Depends on dpq_pkg.
`default_nettype none

module dpq_prep
    import dpq_pkg::*;
(
    input  var dpq_req_t  req,
    output var dpq_prep_t prep
);

    dpq_dec_t dec [4];

    for (genvar k = 0; k < 4; k++) begin : g_oct
        assign dec[k] = to_dec(req.address[8*k +: 8]);
    end

    always_comb begin
        logic [4:0] pos;
        prep.rejected       = ~req.is_ipv4;
        prep.transaction_id = req.transaction_id;
        pos = 5'd0;
        // Lowest-order octet is written first.
        for (int k = 0; k < 4; k++) begin
            prep.ndig[k]  = dec[k].ndig;
            prep.digit[k] = dec[k].digit;
            prep.start[k] = pos;
            pos = pos + 5'd1 + {3'd0, dec[k].ndig};
        end
        prep.tail_start = pos;
        if (req.is_ipv4) begin
            prep.packet_length = {1'b0, pos} + 6'(HDR_LEN + TAIL_LEN);
        end else begin
            prep.packet_length = 6'd0;
        end
    end

endmodule

`default_nettype wire

// File: design/dpq_byte_sel.sv
// Byte selector: gives the packet byte at a position of a described query.
// Depends on dpq_pkg.
`default_nettype none

module dpq_byte_sel
    import dpq_pkg::*;
(
    input  var dpq_prep_t  prep,
    input  var logic [5:0] idx,
    output var dpq_rsp_t   rsp
);

    always_comb begin
        logic [5:0] q;
        logic [4:0] qn;
        logic [5:0] tq;
        logic [4:0] off;
        q  = idx - 6'(HDR_LEN);
        qn = q[4:0];
        // Position within the fixed tail; the question part can reach 34 bytes,
        // so this is worked out at full width.
        tq = q - {1'b0, prep.tail_start};
        rsp.packet_byte   = 8'd0;
        rsp.rejected      = prep.rejected;
        rsp.packet_length = prep.packet_length;
        off = 5'd0;
        if (prep.rejected) begin
            rsp.is_last = 1'b1;
        end else begin
            rsp.is_last = (idx == prep.packet_length - 6'd1);
            if (idx < 6'(HDR_LEN)) begin
                case (idx[3:0])
                    HDR_ID_HI:  rsp.packet_byte = prep.transaction_id[15:8];
                    HDR_ID_LO:  rsp.packet_byte = prep.transaction_id[7:0];
                    HDR_QDC_LO: rsp.packet_byte = 8'd1;
                    default:    rsp.packet_byte = 8'd0;
                endcase
            end else if (q >= {1'b0, prep.tail_start}) begin
                rsp.packet_byte = tail_byte(tq[4:0]);
            end else begin
                // The labels do not overlap, so at most one matches.
                for (int k = 0; k < 4; k++) begin
                    if (qn >= prep.start[k] &&
                        qn <= prep.start[k] + {3'd0, prep.ndig[k]}) begin
                        off = qn - prep.start[k];
                        case (off[1:0])
                            2'd0:    rsp.packet_byte = {6'd0, prep.ndig[k]};
                            2'd1:    rsp.packet_byte = ASCII_ZERO | {4'd0, prep.digit[k][0]};
                            2'd2:    rsp.packet_byte = ASCII_ZERO | {4'd0, prep.digit[k][1]};
                            default: rsp.packet_byte = ASCII_ZERO | {4'd0, prep.digit[k][2]};
                        endcase
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: design/dns_ptr_query_builder.sv
// Top level of the DNS reverse (PTR) query builder.
// Depends on dpq_pkg, dpq_prep and dpq_byte_sel.
//
//   Channel  Direction  Payload    Meaning
//   s_       in         dpq_req_t  one request: address family, IPv4 address, query id
//   m_       out        dpq_rsp_t  one packet byte, with last flag, reject flag and length
//
// Each request transaction yields 38 to 46 result transactions, one per packet byte, or a
// single rejection transaction when the request is not IPv4. The byte serialiser emits one
// byte per cycle while the result channel does not stall; that output byte rate is what
// bounds throughput.
// The next request is taken in the same cycle as the final byte of the current one moves
// into the output register, so packets follow one another without a gap.
// Reset (aresetn, synchronous, active low) empties the item and output registers.
// A stalled result channel holds the byte in the output register and stops the serialiser.
`default_nettype none

module dns_ptr_query_builder
    import dpq_pkg::*;
(
    input  var logic     aclk,
    input  var logic     aresetn,
    input  var logic     s_valid,
    output var logic     s_ready,
    input  var dpq_req_t s_data,
    output var logic     m_valid,
    input  var logic     m_ready,
    output var dpq_rsp_t m_data
);

    dpq_prep_t  prep_next;
    dpq_prep_t  prep_reg;
    logic       item_valid_reg;
    logic [5:0] idx_reg;
    logic       out_valid_reg;
    dpq_rsp_t   out_reg;
    dpq_rsp_t   cur_rsp;
    logic       out_load;
    logic       item_done;
    logic       s_accept;

    // The descriptor is worked out from the request port and stored with the item.
    dpq_prep u_prep (
        .req  (s_data),
        .prep (prep_next)
    );

    // The byte at the current position of the held item.
    dpq_byte_sel u_byte_sel (
        .prep (prep_reg),
        .idx  (idx_reg),
        .rsp  (cur_rsp)
    );

    // A byte moves forward whenever the output register is empty or is being emptied.
    assign out_load  = item_valid_reg && (!out_valid_reg || m_ready);
    assign item_done = out_load && cur_rsp.is_last;
    assign s_ready   = !item_valid_reg || item_done;
    assign s_accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (s_accept) begin
                item_valid_reg <= 1'b1;
            end else if (item_done) begin
                item_valid_reg <= 1'b0;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload and position registers need no reset.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            prep_reg <= prep_next;
            idx_reg  <= 6'd0;
        end else if (out_load) begin
            idx_reg <= idx_reg + 6'd1;
        end
        if (out_load) begin
            out_reg <= cur_rsp;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // The position never runs past the end of a packet.
    assert property (@(posedge aclk) disable iff (!aresetn)
        item_valid_reg && !prep_reg.rejected |-> idx_reg < prep_reg.packet_length)
        else $error("byte position beyond packet length");

    // A built packet is always 38 to 46 bytes long.
    assert property (@(posedge aclk) disable iff (!aresetn)
        item_valid_reg && !prep_reg.rejected |->
            prep_reg.packet_length >= 6'd38 && prep_reg.packet_length <= 6'd46)
        else $error("packet length out of range");

    // A byte that is not the last advances the position by one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && !cur_rsp.is_last |=> item_valid_reg && idx_reg == $past(idx_reg) + 6'd1)
        else $error("serialiser position did not advance");

    // A finished item with no new request leaves the item register empty.
    assert property (@(posedge aclk) disable iff (!aresetn)
        item_done && !s_accept |=> !item_valid_reg)
        else $error("item register not released after last byte");

    // A rejection result is always flagged as last with zero length.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.rejected |->
            out_reg.is_last && out_reg.packet_length == 6'd0)
        else $error("malformed rejection result");

endmodule

`default_nettype wire
